// ===== hw/rtl/spd_pkg.sv =====
// Shared types and constants for the shortest path distance block.
package spd_pkg;

  localparam logic [15:0] DIST_INF = 16'hFFFF;
  localparam logic [15:0] DIST_SAT = 16'hFFFE;
  localparam logic [6:0]  VERTEX_COUNT_RESET = 7'd64;

  typedef enum logic [1:0] {
    OP_HEAD  = 2'd0,
    OP_ARC   = 2'd1,
    OP_QUERY = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INIT,
    ST_SCAN,
    ST_DRAIN,
    ST_PICK,
    ST_HEAD_HI,
    ST_HEAD_CAP,
    ST_ARC_CHECK,
    ST_ARC_RD,
    ST_ARC_DIST,
    ST_ARC_UPD,
    ST_FIN_RD,
    ST_FIN_WAIT,
    ST_OUT_INF
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic accept;       // input transaction taken this cycle
    logic query_init;   // clear per-query state, seed the source
    logic scan_start;   // reset minimum search
    logic scan_step;    // read next vertex distance
    logic settle;       // mark pick done, read its head offset
    logic head_hi;      // take arc start, read next head offset
    logic head_cap;     // take arc end
    logic arc_read;     // read the current arc
    logic arc_dist;     // read distance at arc target
    logic arc_upd;      // relax
    logic fin_read;     // read distance at query target
    logic result_load;  // load the output register
    logic result_inf;   // result is unreachable
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_query;
    logic ends_ok;
    logic scan_last;
    logic found;
    logic arc_more;
    logic out_busy;
  } status_t;

endpackage

// ===== hw/rtl/shortest_path_distance.sv =====
// Top level of the shortest path distance block.
// Load transactions (head offset, arc) leave the sequencer idle; the next item is taken the cycle after.
// A query holds the input through its rounds and any output stall: R settled rounds and a final
// empty round, each with a minimum scan over the n vertices, plus relaxing each arc of a settled vertex.
// A query with an endpoint at or beyond n ends unreachable at once. One item is in work at a time.
// Reset: asynchronous active low, clears control state, vertex_count returns to 64; no clearing pass.
module shortest_path_distance #(
  parameter int MAX_VERTICES = 64,
  parameter int MAX_ARCS     = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [6:0]  cfg_vertex_count_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  operation_i,
  input  logic [7:0]  entry_index_i,
  input  logic [8:0]  entry_value_i,
  input  logic [7:0]  arc_cost_i,
  input  logic [5:0]  source_vertex_i,
  input  logic [5:0]  target_vertex_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] path_distance_o,
  output logic        reachable_o
);
  import spd_pkg::*;

  cmd_t    cmd;
  status_t status;

  assign cfg_ready_o = 1'b1;

  spd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  spd_datapath #(
    .MAX_VERTICES (MAX_VERTICES),
    .MAX_ARCS     (MAX_ARCS)
  ) u_datapath (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .status_o           (status),
    .cfg_we_i           (cfg_valid_i && cfg_ready_o),
    .cfg_vertex_count_i (cfg_vertex_count_i),
    .operation_i        (operation_i),
    .entry_index_i      (entry_index_i),
    .entry_value_i      (entry_value_i),
    .arc_cost_i         (arc_cost_i),
    .source_vertex_i    (source_vertex_i),
    .target_vertex_i    (target_vertex_i),
    .out_stall_i        (out_stall_i),
    .out_valid_o        (out_valid_o),
    .path_distance_o    (path_distance_o),
    .reachable_o        (reachable_o)
  );

endmodule

// ===== hw/rtl/spd_ctrl.sv =====
// Sequencer for load and query transactions.
module spd_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  spd_pkg::status_t status_i,
  output spd_pkg::cmd_t    cmd_o
);
  import spd_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i && status_i.is_query) state_d = ST_INIT;
      end
      ST_INIT:      state_d = status_i.ends_ok ? ST_SCAN : ST_OUT_INF;
      ST_SCAN: begin
        if (status_i.scan_last) state_d = ST_DRAIN;
      end
      ST_DRAIN:     state_d = ST_PICK;
      ST_PICK:      state_d = status_i.found ? ST_HEAD_HI : ST_FIN_RD;
      ST_HEAD_HI:   state_d = ST_HEAD_CAP;
      ST_HEAD_CAP:  state_d = ST_ARC_CHECK;
      ST_ARC_CHECK: state_d = status_i.arc_more ? ST_ARC_RD : ST_SCAN;
      ST_ARC_RD:    state_d = ST_ARC_DIST;
      ST_ARC_DIST:  state_d = ST_ARC_UPD;
      ST_ARC_UPD:   state_d = ST_ARC_CHECK;
      ST_FIN_RD:    state_d = ST_FIN_WAIT;
      ST_FIN_WAIT: begin
        if (!status_i.out_busy) state_d = ST_IDLE;
      end
      ST_OUT_INF: begin
        if (!status_i.out_busy) state_d = ST_IDLE;
      end
      default:      state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_stall_o = (state_q != ST_IDLE);
    case (state_q)
      ST_IDLE:      cmd_o.accept = in_valid_i;
      ST_INIT: begin
        cmd_o.query_init = status_i.ends_ok;
        cmd_o.scan_start = 1'b1;
      end
      ST_SCAN:      cmd_o.scan_step = 1'b1;
      ST_PICK:      cmd_o.settle = status_i.found;
      ST_HEAD_HI:   cmd_o.head_hi = 1'b1;
      ST_HEAD_CAP:  cmd_o.head_cap = 1'b1;
      ST_ARC_CHECK: cmd_o.scan_start = !status_i.arc_more;
      ST_ARC_RD:    cmd_o.arc_read = 1'b1;
      ST_ARC_DIST:  cmd_o.arc_dist = 1'b1;
      ST_ARC_UPD:   cmd_o.arc_upd = 1'b1;
      ST_FIN_RD:    cmd_o.fin_read = 1'b1;
      ST_FIN_WAIT:  cmd_o.result_load = !status_i.out_busy;
      ST_OUT_INF: begin
        cmd_o.result_load = !status_i.out_busy;
        cmd_o.result_inf  = 1'b1;
      end
      default: ;
    endcase
  end

endmodule

// ===== hw/rtl/spd_datapath.sv =====
// Graph storage, distance memory, minimum search and relaxation datapath.
module spd_datapath #(
  parameter int MAX_VERTICES = 64,
  parameter int MAX_ARCS     = 256
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  spd_pkg::cmd_t    cmd_i,
  output spd_pkg::status_t status_o,
  input  logic             cfg_we_i,
  input  logic [6:0]       cfg_vertex_count_i,
  input  logic [1:0]       operation_i,
  input  logic [7:0]       entry_index_i,
  input  logic [8:0]       entry_value_i,
  input  logic [7:0]       arc_cost_i,
  input  logic [5:0]       source_vertex_i,
  input  logic [5:0]       target_vertex_i,
  input  logic             out_stall_i,
  output logic             out_valid_o,
  output logic [15:0]      path_distance_o,
  output logic             reachable_o
);
  import spd_pkg::*;

  localparam int VW = $clog2(MAX_VERTICES);
  localparam int NW = $clog2(MAX_VERTICES + 1);
  localparam int HW = $clog2(MAX_VERTICES + 1);
  localparam int AW = (MAX_ARCS > 1) ? $clog2(MAX_ARCS) : 1;
  localparam int AC = $clog2(MAX_ARCS + 1) > AW ? $clog2(MAX_ARCS + 1) : AW;

  // target modulo MAX_VERTICES by restoring reduction
  function automatic logic [VW-1:0] wrap_target(logic [8:0] v);
    int r;
    r = int'(v);
    for (int k = 8; k >= 0; k--) begin
      if (r >= (MAX_VERTICES << k)) r = r - (MAX_VERTICES << k);
    end
    return VW'(r);
  endfunction

  function automatic logic [AC-1:0] clamp_off(logic [8:0] off);
    if (int'(off) > MAX_ARCS) return AC'(MAX_ARCS);
    return AC'(off);
  endfunction

  // memories
  logic [8:0]    head_mem [MAX_VERTICES+1];
  logic [VW-1:0] arc_tgt_mem [MAX_ARCS];
  logic [7:0]    arc_wgt_mem [MAX_ARCS];
  logic [15:0]   dist_mem [MAX_VERTICES];

  logic [6:0]    cfg_vc_q;
  logic [NW-1:0] n_w;
  logic [5:0]    src_q, dst_q;

  logic [MAX_VERTICES-1:0] dist_vld_q;
  logic [MAX_VERTICES-1:0] settled_q;

  logic [8:0]    head_rdata_q;
  logic [VW-1:0] arc_tgt_q;
  logic [7:0]    arc_wgt_q;
  logic [15:0]   dist_rdata_q;
  logic          dist_rinf_q;
  logic [15:0]   dist_cur;

  logic [VW-1:0] scan_cnt_q;
  logic          pipe_vld_q;
  logic [VW-1:0] pipe_idx_q;
  logic [15:0]   best_q;
  logic [VW-1:0] pick_q;
  logic          found_q;

  logic [AC-1:0] arc_cnt_q, arc_end_q;
  logic [15:0]   sum_q;
  logic [VW-1:0] tgt_q;
  logic          tgt_ok_q;
  logic [16:0]   sum_w;

  logic          dist_we;
  logic [VW-1:0] dist_waddr;
  logic [15:0]   dist_wdata;
  logic          dist_re;
  logic [VW-1:0] dist_raddr;

  logic          out_valid_q;
  logic [15:0]   out_dist_q;

  always_comb begin
    if (cfg_vc_q == '0) begin
      n_w = NW'(1);
    end else if (int'(cfg_vc_q) > MAX_VERTICES) begin
      n_w = NW'(MAX_VERTICES);
    end else begin
      n_w = NW'(cfg_vc_q);
    end
  end

  assign dist_cur = dist_rinf_q ? DIST_INF : dist_rdata_q;

  // graph loads and reads
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept && (operation_i == OP_HEAD) && (int'(entry_index_i) <= MAX_VERTICES)) begin
      head_mem[HW'(entry_index_i)] <= entry_value_i;
    end
    if (cmd_i.accept && (operation_i == OP_ARC) && (int'(entry_index_i) < MAX_ARCS)) begin
      arc_tgt_mem[AW'(entry_index_i)] <= wrap_target(entry_value_i);
      arc_wgt_mem[AW'(entry_index_i)] <= arc_cost_i;
    end
    if (cmd_i.settle) begin
      head_rdata_q <= head_mem[HW'(pick_q)];
    end else if (cmd_i.head_hi) begin
      head_rdata_q <= head_mem[HW'(pick_q) + HW'(1)];
    end
    if (cmd_i.arc_read) begin
      arc_tgt_q <= arc_tgt_mem[arc_cnt_q[AW-1:0]];
      arc_wgt_q <= arc_wgt_mem[arc_cnt_q[AW-1:0]];
    end
  end

  // distance memory port control
  always_comb begin
    dist_we    = 1'b0;
    dist_waddr = VW'(src_q);
    dist_wdata = '0;
    if (cmd_i.query_init) begin
      dist_we = 1'b1;
    end else if (cmd_i.arc_upd && tgt_ok_q && (sum_q < dist_cur)) begin
      dist_we    = 1'b1;
      dist_waddr = tgt_q;
      dist_wdata = sum_q;
    end
    dist_re    = cmd_i.scan_step || cmd_i.arc_dist || cmd_i.fin_read;
    dist_raddr = scan_cnt_q;
    if (cmd_i.arc_dist) begin
      dist_raddr = arc_tgt_q;
    end else if (cmd_i.fin_read) begin
      dist_raddr = VW'(dst_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (dist_we) dist_mem[dist_waddr] <= dist_wdata;
    if (dist_re) begin
      dist_rdata_q <= dist_mem[dist_raddr];
      dist_rinf_q  <= !dist_vld_q[dist_raddr];
    end
  end

  assign sum_w = {1'b0, best_q} + 17'(arc_wgt_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_vc_q    <= VERTEX_COUNT_RESET;
      dist_vld_q  <= '0;
      settled_q   <= '0;
      pipe_vld_q  <= 1'b0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) cfg_vc_q <= cfg_vertex_count_i;
      if (cmd_i.query_init) begin
        // only the source holds a written distance
        dist_vld_q <= MAX_VERTICES'(1) << VW'(src_q);
        settled_q  <= '0;
      end else if (dist_we) begin
        dist_vld_q[dist_waddr] <= 1'b1;
      end
      if (cmd_i.settle) settled_q[pick_q] <= 1'b1;
      pipe_vld_q <= cmd_i.scan_step;
      if (cmd_i.scan_start) begin
        found_q <= 1'b0;
      end else if (pipe_vld_q && !settled_q[pipe_idx_q] && (dist_cur < best_q)) begin
        found_q <= 1'b1;
      end
      if (cmd_i.result_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept && (operation_i == OP_QUERY)) begin
      src_q <= source_vertex_i;
      dst_q <= target_vertex_i;
    end
    pipe_idx_q <= scan_cnt_q;
    if (cmd_i.scan_start) begin
      scan_cnt_q <= '0;
      best_q     <= DIST_INF;
      pick_q     <= '0;
    end else begin
      if (cmd_i.scan_step) scan_cnt_q <= scan_cnt_q + VW'(1);
      if (pipe_vld_q && !settled_q[pipe_idx_q] && (dist_cur < best_q)) begin
        best_q <= dist_cur;
        pick_q <= pipe_idx_q;
      end
    end
    if (cmd_i.head_hi) arc_cnt_q <= clamp_off(head_rdata_q);
    else if (cmd_i.arc_read) arc_cnt_q <= arc_cnt_q + AC'(1);
    if (cmd_i.head_cap) arc_end_q <= clamp_off(head_rdata_q);
    if (cmd_i.arc_dist) begin
      sum_q    <= (sum_w > 17'(DIST_SAT)) ? DIST_SAT : sum_w[15:0];
      tgt_q    <= arc_tgt_q;
      tgt_ok_q <= (int'(arc_tgt_q) < int'(n_w));
    end
    if (cmd_i.result_load) begin
      out_dist_q <= cmd_i.result_inf ? DIST_INF : dist_cur;
    end
  end

  assign status_o.is_query  = (operation_i == OP_QUERY);
  assign status_o.ends_ok   = (int'(src_q) < int'(n_w)) && (int'(dst_q) < int'(n_w));
  assign status_o.scan_last = (scan_cnt_q == VW'(n_w - NW'(1)));
  assign status_o.found     = found_q;
  assign status_o.arc_more  = (arc_cnt_q < arc_end_q);
  assign status_o.out_busy  = out_valid_q && out_stall_i;

  assign out_valid_o     = out_valid_q;
  assign path_distance_o = out_dist_q;
  assign reachable_o     = (out_dist_q != DIST_INF);

`ifndef SYNTHESIS
  a_settle_open: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.settle |-> found_q && !settled_q[pick_q])
    else $error("settling a vertex that is already done");
  a_scan_reset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.scan_start |=> !found_q)
    else $error("minimum search not reset");
  a_best_finite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    found_q |-> best_q != DIST_INF)
    else $error("picked vertex at infinity");
  a_arc_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.arc_read |-> int'(arc_cnt_q) < MAX_ARCS)
    else $error("arc index out of range");
`endif

endmodule

// ===== tb/tb_shortest_path_distance.sv =====
// Testbench for the shortest path distance block: graph loads, queries, self-checking.
module tb_shortest_path_distance;
  timeunit 1ns;
  timeprecision 1ps;

  import spd_pkg::*;

  localparam int NV = 64;
  localparam int NA = 256;

  // Tracks the loaded graph and predicts query distances in order.
  class dist_board;
    bit [8:0]  heads[NV+1];
    bit [5:0]  tgts[NA];
    bit [7:0]  wts[NA];
    bit [6:0]  vcount;
    bit [15:0] want_dist[$];
    bit        want_reach[$];
    int        errors;
    int        checked;

    function new();
      vcount = VERTEX_COUNT_RESET;
    endfunction

    function void set_count(bit [6:0] v);
      vcount = v;
    endfunction

    function int pending();
      return want_dist.size();
    endfunction

    function bit [15:0] shortest(bit [5:0] src, bit [5:0] dst);
      int n, pick, lo, hi;
      bit [16:0] sum;
      bit [15:0] best;
      bit [15:0] tent[NV];
      bit        done[NV];
      bit        found;
      n = (vcount == 0) ? 1 : ((vcount > NV) ? NV : vcount);
      for (int v = 0; v < NV; v++) begin
        tent[v] = DIST_INF;
        done[v] = 1'b0;
      end
      if (src >= n || dst >= n) return DIST_INF;
      tent[src] = '0;
      for (int r = 0; r < n; r++) begin
        best = DIST_INF;
        pick = 0;
        found = 1'b0;
        for (int v = 0; v < n; v++) begin
          if (!done[v] && tent[v] < best) begin
            best = tent[v];
            pick = v;
            found = 1'b1;
          end
        end
        if (!found) break;
        done[pick] = 1'b1;
        lo = (heads[pick] > NA) ? NA : heads[pick];
        hi = (heads[pick+1] > NA) ? NA : heads[pick+1];
        for (int a = lo; a < hi; a++) begin
          if (tgts[a] >= n) continue;
          sum = best + wts[a];
          if (sum > DIST_SAT) sum = DIST_SAT;
          if (sum[15:0] < tent[tgts[a]]) tent[tgts[a]] = sum[15:0];
        end
      end
      return tent[dst];
    endfunction

    function void note_item(op_e op, bit [7:0] idx, bit [8:0] val, bit [7:0] cost,
                            bit [5:0] src, bit [5:0] dst);
      bit [15:0] d;
      case (op)
        OP_HEAD: begin
          if (idx <= NV) heads[idx] = val;
        end
        OP_ARC: begin
          tgts[idx] = val[5:0];
          wts[idx] = cost;
        end
        OP_QUERY: begin
          d = shortest(src, dst);
          want_dist.push_back(d);
          want_reach.push_back(d != DIST_INF);
        end
        default: ;
      endcase
    endfunction

    function void check_result(bit [15:0] d, bit r);
      bit [15:0] ed;
      bit        er;
      checked++;
      if (want_dist.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result: dist %0d reachable %0b", d, r);
        return;
      end
      ed = want_dist.pop_front();
      er = want_reach.pop_front();
      if (ed !== d || er !== r) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: dist exp %0d got %0d, reachable exp %0b got %0b",
                   ed, d, er, r);
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [6:0]  cfg_vertex_count_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [1:0]  operation_i = OP_NONE;
  logic [7:0]  entry_index_i = '0;
  logic [8:0]  entry_value_i = '0;
  logic [7:0]  arc_cost_i = '0;
  logic [5:0]  source_vertex_i = '0;
  logic [5:0]  target_vertex_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [15:0] path_distance_o;
  logic        reachable_o;

  dist_board board = new();
  int idle_pct = 0;
  int stall_pct = 0;
  int n_items = 0;
  int n_queries = 0;
  int n_graphs = 0;

  shortest_path_distance i_dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_ready_o        (cfg_ready_o),
    .cfg_vertex_count_i (cfg_vertex_count_i),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .operation_i        (operation_i),
    .entry_index_i      (entry_index_i),
    .entry_value_i      (entry_value_i),
    .arc_cost_i         (arc_cost_i),
    .source_vertex_i    (source_vertex_i),
    .target_vertex_i    (target_vertex_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .path_distance_o    (path_distance_o),
    .reachable_o        (reachable_o)
  );

  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  // result side: check accepted transactions, stall at random
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      board.check_result(path_distance_o, reachable_o);
    out_stall_i <= ($urandom_range(99) < stall_pct);
  end

  task automatic send_item(op_e op, bit [7:0] idx, bit [8:0] val, bit [7:0] cost,
                           bit [5:0] src, bit [5:0] dst);
    if ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    operation_i     <= op;
    entry_index_i   <= idx;
    entry_value_i   <= val;
    arc_cost_i      <= cost;
    source_vertex_i <= src;
    target_vertex_i <= dst;
    do @(posedge clk_i); while (in_stall_o);
    board.note_item(op, idx, val, cost, src, dst);
    n_items++;
    if (op == OP_QUERY) n_queries++;
  endtask

  task automatic load_head(bit [7:0] idx, bit [8:0] val);
    send_item(OP_HEAD, idx, val, 8'($urandom), 6'($urandom), 6'($urandom));
  endtask

  task automatic load_arc(bit [7:0] idx, bit [8:0] val, bit [7:0] cost);
    send_item(OP_ARC, idx, val, cost, 6'($urandom), 6'($urandom));
  endtask

  task automatic ask(bit [5:0] src, bit [5:0] dst);
    send_item(OP_QUERY, 8'($urandom), 9'($urandom), 8'($urandom), src, dst);
  endtask

  // block must be quiet before a register write; loads leave no result to wait on
  task automatic drain();
    in_valid_i <= 1'b0;
    while (board.pending() > 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic set_vertices(bit [6:0] v);
    drain();
    cfg_valid_i        <= 1'b1;
    cfg_vertex_count_i <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    board.set_count(v);
  endtask

  task automatic noise();
    if ($urandom_range(1))
      send_item(OP_NONE, 8'($urandom), 9'($urandom), 8'($urandom), 6'($urandom),
                6'($urandom));
    else
      load_head(8'($urandom_range(NV + 1, 255)), 9'($urandom));
  endtask

  // random graph on vertices 0..n-1 in a random window of the arc store, then queries;
  // when the configured count exceeds n, arcs and sources stay below n
  task automatic build_graph(int n, int max_deg, bit [6:0] cnt);
    int deg[NV];
    int m, base, off, eff;
    bit [5:0] t;
    bit narrow;
    m = 0;
    for (int v = 0; v < n; v++) begin
      deg[v] = $urandom_range(0, max_deg);
      m += deg[v];
    end
    eff = (cnt == 0) ? 1 : ((cnt > NV) ? NV : int'(cnt));
    narrow = (eff > n);
    set_vertices(cnt);
    base = $urandom_range(0, NA - m);
    off = base;
    for (int v = 0; v <= n; v++) begin
      if ($urandom_range(9) == 0) noise();
      load_head(8'(v), 9'(off));
      if (v < n) off += deg[v];
    end
    for (int a = base; a < base + m; a++) begin
      if ($urandom_range(9) == 0) noise();
      if (narrow || $urandom_range(7) != 0) t = 6'($urandom_range(0, n - 1));
      else t = 6'($urandom_range(0, 63));
      case ($urandom_range(5))
        0: load_arc(8'(a), 9'(t + 64 * $urandom_range(0, 7)), 8'd0);
        1: load_arc(8'(a), 9'(t + 64 * $urandom_range(0, 7)), 8'd255);
        default: load_arc(8'(a), 9'(t + 64 * $urandom_range(0, 7)), 8'($urandom));
      endcase
    end
    repeat ($urandom_range(3, 6)) begin
      if ($urandom_range(5) == 0) begin
        if (narrow) ask(6'($urandom_range(0, n - 1)), 6'($urandom));
        else ask(6'($urandom), 6'($urandom));
      end else begin
        ask(6'($urandom_range(0, n - 1)), 6'($urandom_range(0, n - 1)));
      end
    end
    n_graphs++;
  endtask

  initial begin
    int nv;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // three vertices: a short detour beats a costly direct arc
    set_vertices(7'd3);
    load_head(0, 0);
    load_head(1, 2);
    load_head(2, 3);
    load_head(3, 4);
    load_head(255, 511);              // slot out of range, ignored
    load_head(65, 1);                 // just past the last slot, ignored
    load_arc(0, 1, 8'd0);
    load_arc(1, 258, 8'd255);         // target wraps to 2
    load_arc(2, 130, 8'd7);
    load_arc(3, 63, 8'd1);            // target beyond count, skipped
    send_item(OP_NONE, 8'hFF, 9'h1FF, 8'hFF, 6'h3F, 6'h3F);
    ask(0, 2);
    ask(0, 0);
    ask(2, 0);
    ask(0, 63);
    ask(63, 0);
    // count 0 acts as one vertex; saturated and inverted arc ranges hold nothing
    set_vertices(7'd0);
    load_head(0, 260);
    load_head(1, 511);
    ask(0, 0);
    ask(0, 1);
    load_head(0, 9);
    load_head(1, 5);
    ask(0, 0);

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 60; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 60; end
        default: begin idle_pct = 10; stall_pct = 10; end
      endcase
      // full vertex count with a small loaded graph: the scan covers all 64 vertices
      if (ph == 0)
        build_graph($urandom_range(4, 8), 2, $urandom_range(1) ? 7'd127 : 7'd64);
      nv = $urandom_range(2, 8);
      build_graph(nv, 3, 7'(nv));
      if (ph == 3) build_graph(1, 2, $urandom_range(1) ? 7'd0 : 7'd1);
    end

    drain();
    repeat (50) @(posedge clk_i);
    if (board.pending() > 0) board.errors++;
    $display("covered %0d transactions over %0d graphs, %0d queries, %0d results checked",
             n_items, n_graphs + 2, n_queries, board.checked);
    $display("vertex counts from 0 to 127, idle and stall rates up to 60 percent");
    if (board.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
